>>> rtl/ksel_pkg.sv
// Package for the k-th smallest selector.
// Holds the sequencer state type, the count unit control struct and the rank width.
// No dependencies.
`default_nettype none
package ksel_pkg;

    localparam int RANK_W = 11;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CAND,
        S_CAND_D,
        S_SCAN,
        S_SCAN_D,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic clear;
        logic enable;
    } t_cnt_ctrl;

endpackage
`default_nettype wire

>>> rtl/ksel_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ksel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ksel_count_unit.sv
// Shared compare unit: counts elements below and equal to the current candidate.
// Depends on ksel_pkg.
`default_nettype none
module ksel_count_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 11
) (
    input  wire logic                   i_clk,
    input  wire ksel_pkg::t_cnt_ctrl    i_ctrl,
    input  wire logic [DATA_WIDTH-1:0]  i_cand,
    input  wire logic [DATA_WIDTH-1:0]  i_elem,
    output logic      [CW-1:0]          o_below,
    output logic      [CW-1:0]          o_same
);

    logic [CW-1:0] r_below, n_below;
    logic [CW-1:0] r_same, n_same;

    always_comb begin
        n_below = r_below;
        n_same  = r_same;
        if (i_ctrl.clear) begin
            n_below = '0;
            n_same  = '0;
        end else if (i_ctrl.enable) begin
            if ($signed(i_elem) < $signed(i_cand)) begin
                n_below = r_below + CW'(1);
            end else if (i_elem == i_cand) begin
                n_same = r_same + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_below <= n_below;
        r_same  <= n_same;
    end

    assign o_below = r_below;
    assign o_same  = r_same;

endmodule
`default_nettype wire

>>> rtl/kth_smallest_select.sv
// Top level of the k-th smallest selector: handshake, element store, sequencer.
// Depends on ksel_pkg, ksel_ram and ksel_count_unit.
//
// Elements load one per cycle, while the input is ready, into the element
// store; an element beyond MAX_ELEMENTS is dropped. The request marked
// last_element also carries the 1-based rank and starts selection. A bad
// rank (zero or above the loaded count) answers in the next cycle with
// rank_error set and a zero value. Otherwise each stored element is taken in
// turn as candidate and the whole set is scanned through the single read
// port of the store, one compare after another (read in S_SCAN, count in
// S_SCAN_D), counting values below and equal; the first candidate whose
// range covers the rank is the result. The input is not ready during
// selection.
`default_nettype none
module kth_smallest_select #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [DATA_WIDTH-1:0]  i_element_value,
    input  wire logic                   i_last_element,
    input  wire logic [ksel_pkg::RANK_W-1:0] i_rank,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [DATA_WIDTH-1:0]       o_selected_value,
    output logic                        o_rank_error
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int KW = ((CW > ksel_pkg::RANK_W) ? CW : ksel_pkg::RANK_W) + 1;

    ksel_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_i, n_i, r_j, n_j, r_last, n_last;
    logic [KW-1:0]  r_k, n_k;
    logic [DATA_WIDTH-1:0] r_cand, n_cand;
    logic           r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value, n_out_value;
    logic           r_out_err, n_out_err;

    logic           we, accept, store_ok;
    logic [AW-1:0]  raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic [CW-1:0]  below, same, total;
    logic [KW-1:0]  below_x, upper_x;
    ksel_pkg::t_cnt_ctrl cnt_ctrl;

    assign o_ready  = (r_state == ksel_pkg::S_LOAD) && !(r_out_valid && i_last_element);
    assign accept   = i_valid && o_ready;
    assign store_ok = (r_count < CW'(MAX_ELEMENTS));
    assign we       = accept && store_ok;
    assign total    = r_count + (store_ok ? CW'(1) : CW'(0));
    assign below_x  = KW'(below);
    assign upper_x  = KW'(below) + KW'(same);

    ksel_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ksel_count_unit #(.DATA_WIDTH(DATA_WIDTH), .CW(CW)) u_count (
        .i_clk   (i_clk),
        .i_ctrl  (cnt_ctrl),
        .i_cand  (r_cand),
        .i_elem  (rdata),
        .o_below (below),
        .o_same  (same)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_last      = r_last;
        n_k         = r_k;
        n_cand      = r_cand;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        raddr       = r_j;
        cnt_ctrl    = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ksel_pkg::S_LOAD: begin
                if (accept) begin
                    n_count = total;
                    if (i_last_element) begin
                        n_count = '0;
                        if (i_rank == '0 || KW'(i_rank) > KW'(total)) begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_err   = 1'b1;
                        end else begin
                            n_k     = KW'(i_rank);
                            n_last  = AW'(total - CW'(1));
                            n_i     = '0;
                            n_state = ksel_pkg::S_CAND;
                        end
                    end
                end
            end
            ksel_pkg::S_CAND: begin
                raddr   = r_i;
                n_state = ksel_pkg::S_CAND_D;
            end
            ksel_pkg::S_CAND_D: begin
                n_cand         = rdata;
                n_j            = '0;
                cnt_ctrl.clear = 1'b1;
                n_state        = ksel_pkg::S_SCAN;
            end
            ksel_pkg::S_SCAN: begin
                n_state = ksel_pkg::S_SCAN_D;
            end
            ksel_pkg::S_SCAN_D: begin
                cnt_ctrl.enable = 1'b1;
                if (r_j == r_last) begin
                    n_state = ksel_pkg::S_CHECK;
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = ksel_pkg::S_SCAN;
                end
            end
            ksel_pkg::S_CHECK: begin
                if (below_x < r_k && r_k <= upper_x) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_cand;
                    n_out_err   = 1'b0;
                    n_state     = ksel_pkg::S_LOAD;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = ksel_pkg::S_CAND;
                end
            end
            default: n_state = ksel_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ksel_pkg::S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_last      <= n_last;
        r_k         <= n_k;
        r_cand      <= n_cand;
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    assign o_valid          = r_out_valid;
    assign o_selected_value = r_out_value;
    assign o_rank_error     = r_out_err;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("fill count beyond store depth");

    // a result only appears while the block is back in load state
    a_result_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_state == ksel_pkg::S_LOAD)
        else $error("result raised outside load state");

    // a scan never starts with a zero rank
    a_rank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ksel_pkg::S_SCAN) |-> r_k != '0)
        else $error("zero rank in scan");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> r_out_value == '0)
        else $error("error result with nonzero value");

endmodule
`default_nettype wire

>>> tb/kth_smallest_select_tb.sv
// Testbench for kth_smallest_select: loads element sets and checks the selected rank.
// Depends on ksel_pkg and kth_smallest_select; self-checking with a sorting predictor.
`default_nettype none
module kth_smallest_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EL = 1024;
    localparam int RANK_W = ksel_pkg::RANK_W;

    typedef struct {
        logic [31:0] value;
        logic        err;
    } t_selection;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [31:0]       i_element_value;
    logic              i_last_element;
    logic [RANK_W-1:0] i_rank;
    logic              o_valid;
    logic              i_ready;
    logic [31:0]       o_selected_value;
    logic              o_rank_error;

    logic signed [31:0] held_set[$];
    t_selection         pending_selections[$];
    int                 fail_count = 0;
    int                 items_sent = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;
    int                 rx_hold_len = 0;

    kth_smallest_select dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_element_value  (i_element_value),
        .i_last_element   (i_last_element),
        .i_rank           (i_rank),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_selected_value (o_selected_value),
        .o_rank_error     (o_rank_error)
    );

    always #5 i_clk = ~i_clk;

    // k-th smallest (1-based) of the held set, by insertion sort on a copy
    function automatic logic [31:0] kth_smallest(input int k);
        logic signed [31:0] s[$];
        logic signed [31:0] key;
        int j;
        s = held_set;
        for (int i = 1; i < s.size(); i++) begin
            key = s[i];
            j = i;
            while (j > 0 && s[j-1] > key) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = key;
        end
        return s[k-1];
    endfunction

    task automatic record_request(input logic [31:0] v, input bit last, input int r);
        t_selection sel;
        if (held_set.size() < MAX_EL) held_set.push_back(v);
        if (last) begin
            if (r == 0 || r > held_set.size()) begin
                sel.value = '0;
                sel.err = 1'b1;
            end else begin
                sel.value = kth_smallest(r);
                sel.err = 1'b0;
            end
            pending_selections.push_back(sel);
            held_set.delete();
        end
    endtask

    // Handshake state changes only at rising edges, so it is read at the falling edge.
    task automatic send_request(input logic [31:0] v, input bit last, input logic [RANK_W-1:0] r);
        while (tx_idle_on && $urandom_range(0, 99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_element_value <= v;
        i_last_element <= last;
        i_rank <= r;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        record_request(v, last, r);
        items_sent++;
    endtask

    task automatic send_set(input logic [31:0] vals[$], input logic [RANK_W-1:0] r);
        for (int i = 0; i < vals.size(); i++)
            send_request(vals[i], i == vals.size() - 1,
                         (i == vals.size() - 1) ? r : RANK_W'($urandom));
    endtask

    task automatic test_extremes();
        logic [31:0] v[$];
        v = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h1};
        send_set(v, 1);
        send_set(v, 5);
        send_set(v, 3);
        v = '{32'h80000000};
        send_set(v, 1);
        v = '{32'h7fffffff};
        send_set(v, 1);
    endtask

    task automatic test_bad_rank();
        logic [31:0] v[$];
        v = '{32'd7, 32'd3};
        send_set(v, 0);
        send_set(v, 3);
        v = '{32'hdeadbeef};
        send_set(v, RANK_W'(2047));
    endtask

    task automatic test_duplicates();
        logic [31:0] v[$];
        v = '{32'd4, 32'd4, 32'hfffffffe, 32'd4, 32'hfffffffe, 32'd4};
        send_set(v, 2);
        send_set(v, 4);
    endtask

    // More than a full store: the last three elements are dropped but selection still runs.
    // The first element is the unique minimum, so the first candidate already matches.
    task automatic test_store_full(input int rank_sel);
        logic [31:0] v[$];
        for (int i = 0; i < MAX_EL + 3; i++)
            v.push_back(i == 0 ? 32'h80000000 : 32'h80000001 + $urandom_range(0, 1 << 30));
        send_set(v, rank_sel);
    endtask

    // Receiver stalls long while sets keep coming; the input must stall too.
    task automatic test_backpressure();
        logic [31:0] v[$];
        rx_hold_len = 400;
        for (int s = 0; s < 4; s++) begin
            v.delete();
            for (int i = 0; i < 6; i++) v.push_back($urandom);
            send_set(v, $urandom_range(1, 6));
        end
    endtask

    task automatic test_random(input int target);
        logic [31:0] v[$];
        int n;
        int lo;
        int start;
        logic [RANK_W-1:0] r;
        start = items_sent;
        while (items_sent < target) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            lo = $urandom_range(0, 2);
            v.delete();
            for (int i = 0; i < n; i++)
                v.push_back(lo == 0 ? 32'($signed($urandom_range(0, 6)) - 3) : $urandom);
            case ($urandom_range(0, 19))
                0:       r = 0;
                1:       r = RANK_W'($urandom);
                2:       r = RANK_W'(n + 1);
                default: r = RANK_W'($urandom_range(1, n));
            endcase
            send_set(v, r);
            if (items_sent - start > (target - start) / 3 &&
                items_sent - start < (target - start) / 2) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
        end
    endtask

    // Receiver ready, with random idling and an occasional long hold-off
    initial begin
        int held;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                i_ready <= 1'b0;
                for (held = 0; held < rx_hold_len; held++) @(posedge i_clk);
                rx_hold_len = 0;
            end
            i_ready <= !(rx_idle_on && $urandom_range(0, 99) < 26);
        end
    end

    always @(negedge i_clk) begin
        t_selection sel;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_selections.size() == 0) begin
                $error("unexpected result: selected_value %0d rank_error %0b",
                       $signed(o_selected_value), o_rank_error);
                fail_count++;
            end else begin
                sel = pending_selections.pop_front();
                if (o_selected_value !== sel.value) begin
                    $error("selected_value expected %0d actual %0d",
                           $signed(sel.value), $signed(o_selected_value));
                    fail_count++;
                end
                if (o_rank_error !== sel.err) begin
                    $error("rank_error expected %0b actual %0b", sel.err, o_rank_error);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_element_value <= '0;
        i_last_element <= 1'b0;
        i_rank <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_bad_rank();
        test_duplicates();
        test_store_full(1);
        test_backpressure();
        test_random(1500);

        i_valid <= 1'b0;
        while (pending_selections.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
rtl/ksel_pkg.sv
rtl/ksel_ram.sv
rtl/ksel_count_unit.sv
rtl/kth_smallest_select.sv
tb/kth_smallest_select_tb.sv
